@@ design/mrt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mrt_pkg - shared types for the memory region table lookup core
// Result codes, controller/datapath command and status bundles, result
// field layout and the contract decode.
// ---------------------------------------------------------------------------
package mrt_pkg;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 24;
    localparam int RES_W     = 20;

    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_HIT      = 3'd3;
    localparam logic [2:0] STAT_MISS     = 3'd4;

    localparam logic [1:0] RSEL_SCAN  = 2'd0;
    localparam logic [1:0] RSEL_SHIFT = 2'd1;
    localparam logic [1:0] RSEL_MID   = 2'd2;

    localparam logic [1:0] RSRC_ZERO = 2'd0;
    localparam logic [1:0] RSRC_NEW  = 2'd1;
    localparam logic [1:0] RSRC_HIT  = 2'd2;

    localparam logic [2:0] KIND_DYN_EXEC  = 3'd3;
    localparam logic [2:0] KIND_MOD_CAND  = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       scan_clr;
        logic       scan_inc;
        logic       set_pos;
        logic       shift_init;
        logic       shift_dec;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_shift;
        logic       wr_new;
        logic       lk_init;
        logic       lk_step;
        logic       set_res;
        logic [1:0] res_src;
        logic [2:0] res_status;
        logic       out_load;
    } mrt_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic empty_range;
        logic table_full;
        logic scan_end;
        logic scan_past;
        logic shift_end;
        logic lk_end;
        logic lk_hit;
        logic out_free;
    } mrt_sts_t;

    // first member sits in the top bits
    typedef struct packed {
        logic       write_violation;
        logic       exec_violation;
        logic       may_retarget_edges;
        logic       may_drift_symbols;
        logic       may_change_perms;
        logic       may_become_exec;
        logic [2:0] seen_perms;
        logic [2:0] declared_perms;
        logic [2:0] kind_out;
        logic [4:0] region_number;
    } res_t;

    function automatic res_t make_res(input logic [4:0] id, input logic [2:0] kind,
                                      input logic [2:0] decl, input logic [2:0] seen);
        res_t r;
        logic both;
        logic loose;
        both  = (kind == KIND_DYN_EXEC) || (kind == KIND_MOD_CAND);
        loose = (kind >= KIND_DYN_EXEC);
        r.region_number      = id;
        r.kind_out           = kind;
        r.declared_perms     = decl;
        r.seen_perms         = seen;
        r.may_become_exec    = both;
        r.may_change_perms   = both;
        r.may_drift_symbols  = loose;
        r.may_retarget_edges = loose;
        r.exec_violation     = !decl[0] && seen[0];
        r.write_violation    = !decl[1] && seen[1];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/mrt_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mrt_datapath - region table storage and search datapath
// Holds the captured beat, the sorted start/end/attribute memories, the
// scan, shift and binary search indices, and the result register.
// ---------------------------------------------------------------------------
module mrt_datapath
    import mrt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire mrt_cmd_t             cmd,
    output mrt_sts_t                  sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [2:0]                m_tuser
);

    localparam int AW     = $clog2(MAX_REGIONS);
    localparam int CW     = $clog2(MAX_REGIONS + 1);
    localparam int ATTR_W = CW + 9;

    logic              act_reg;
    logic [63:0]       start_reg;
    logic [63:0]       end_reg;
    logic [2:0]        kind_reg;
    logic [2:0]        decl_reg;
    logic [2:0]        seen_reg;
    logic [63:0]       addr_reg;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;

    logic [63:0]       start_mem [MAX_REGIONS];
    logic [63:0]       end_mem   [MAX_REGIONS];
    logic [ATTR_W-1:0] attr_mem  [MAX_REGIONS];
    logic [63:0]       rd_start_reg;
    logic [63:0]       rd_end_reg;
    logic [ATTR_W-1:0] rd_attr_reg;

    res_t              pend_res_reg;
    logic [2:0]        pend_stat_reg;
    res_t              out_res_reg;
    logic [2:0]        out_stat_reg;
    logic              out_valid_reg;

    logic [CW-1:0]     count_inc;
    logic [CW-1:0]     j_dec;
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [ATTR_W-1:0] new_attr;
    res_t              res_next;

    assign count_inc = count_reg + {{(CW-1){1'b0}}, 1'b1};
    assign j_dec     = j_reg - {{(CW-1){1'b0}}, 1'b1};
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid       = mid_sum[CW:1];
    assign new_attr  = {count_inc, kind_reg, decl_reg, seen_reg};
    assign wr_addr   = cmd.wr_new ? pos_reg[AW-1:0] : j_reg[AW-1:0];

    always_comb begin
        unique case (cmd.rd_sel)
            RSEL_SCAN:  rd_addr = idx_reg[AW-1:0];
            RSEL_SHIFT: rd_addr = j_dec[AW-1:0];
            RSEL_MID:   rd_addr = mid[AW-1:0];
            default:    rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_comb begin
        case (cmd.res_src)
            RSRC_NEW: res_next = make_res(5'(count_inc), kind_reg, decl_reg, seen_reg);
            RSRC_HIT: res_next = make_res(5'(rd_attr_reg[ATTR_W-1:9]), rd_attr_reg[8:6],
                                          rd_attr_reg[5:3], rd_attr_reg[2:0]);
            default:  res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= s_tuser;
            start_reg <= s_tdata[63:0];
            end_reg   <= s_tdata[127:64];
            kind_reg  <= s_tdata[130:128];
            decl_reg  <= {s_tdata[131], s_tdata[132], s_tdata[133]};
            seen_reg  <= {s_tdata[134], s_tdata[135], s_tdata[136]};
            addr_reg  <= s_tdata[200:137];
        end
        if (cmd.rd_en) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
            rd_attr_reg  <= attr_mem[rd_addr];
        end
        if (cmd.wr_new) begin
            start_mem[wr_addr] <= start_reg;
            end_mem[wr_addr]   <= end_reg;
            attr_mem[wr_addr]  <= new_attr;
        end else if (cmd.wr_shift) begin
            start_mem[wr_addr] <= rd_start_reg;
            end_mem[wr_addr]   <= rd_end_reg;
            attr_mem[wr_addr]  <= rd_attr_reg;
        end
        if (cmd.scan_clr) begin
            idx_reg <= '0;
        end else if (cmd.scan_inc) begin
            idx_reg <= idx_reg + {{(CW-1){1'b0}}, 1'b1};
        end
        if (cmd.set_pos) begin
            pos_reg <= idx_reg;
        end
        if (cmd.shift_init) begin
            j_reg <= count_reg;
        end else if (cmd.shift_dec) begin
            j_reg <= j_dec;
        end
        if (cmd.lk_init) begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end else if (cmd.lk_step) begin
            if (addr_reg < rd_start_reg) begin
                hi_reg <= mid;
            end else begin
                lo_reg <= mid + {{(CW-1){1'b0}}, 1'b1};
            end
        end
        if (cmd.set_res) begin
            pend_res_reg  <= res_next;
            pend_stat_reg <= cmd.res_status;
        end
        if (cmd.out_load) begin
            out_res_reg  <= pend_res_reg;
            out_stat_reg <= pend_stat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_new) begin
                count_reg <= count_inc;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_lookup   = act_reg;
    assign sts.empty_range = start_reg >= end_reg;
    assign sts.table_full  = count_reg == CW'(MAX_REGIONS);
    assign sts.scan_end    = idx_reg == count_reg;
    assign sts.scan_past   = rd_start_reg > start_reg;
    assign sts.shift_end   = j_reg == pos_reg;
    assign sts.lk_end      = lo_reg >= hi_reg;
    assign sts.lk_hit      = (addr_reg >= rd_start_reg) && (addr_reg < rd_end_reg);
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_res_reg};
    assign m_tuser  = out_stat_reg;

endmodule
`default_nettype wire

@@ design/mrt_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mrt_ctrl - region table sequencing controller
// Steps one beat at a time through the insert scan and shift or the
// binary search, then hands the result to the output register.
// ---------------------------------------------------------------------------
module mrt_ctrl
    import mrt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire mrt_sts_t sts,
    output mrt_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CHECK    = 4'd1;
    localparam logic [3:0] ST_SCAN_RD  = 4'd2;
    localparam logic [3:0] ST_SCAN_CMP = 4'd3;
    localparam logic [3:0] ST_SHIFT_RD = 4'd4;
    localparam logic [3:0] ST_SHIFT_WR = 4'd5;
    localparam logic [3:0] ST_LK_RD    = 4'd6;
    localparam logic [3:0] ST_LK_CMP   = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.is_lookup) begin
                    cmd.lk_init = 1'b1;
                    state_next  = ST_LK_RD;
                end else if (sts.empty_range) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RSRC_ZERO;
                    cmd.res_status = STAT_EMPTY;
                    state_next     = ST_DONE;
                end else if (sts.table_full) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RSRC_ZERO;
                    cmd.res_status = STAT_FULL;
                    state_next     = ST_DONE;
                end else begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (sts.scan_end) begin
                    cmd.set_pos    = 1'b1;
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_RD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RSEL_SCAN;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (sts.scan_past) begin
                    cmd.set_pos    = 1'b1;
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_RD;
                end else begin
                    cmd.scan_inc = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (sts.shift_end) begin
                    cmd.wr_new     = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RSRC_NEW;
                    cmd.res_status = STAT_INSERTED;
                    state_next     = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RSEL_SHIFT;
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.wr_shift  = 1'b1;
                cmd.shift_dec = 1'b1;
                state_next    = ST_SHIFT_RD;
            end
            ST_LK_RD: begin
                if (sts.lk_end) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RSRC_ZERO;
                    cmd.res_status = STAT_MISS;
                    state_next     = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RSEL_MID;
                    state_next = ST_LK_CMP;
                end
            end
            ST_LK_CMP: begin
                if (sts.lk_hit) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RSRC_HIT;
                    cmd.res_status = STAT_HIT;
                    state_next     = ST_DONE;
                end else begin
                    cmd.lk_step = 1'b1;
                    state_next  = ST_LK_RD;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ design/memory_region_table_lookup_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// memory_region_table_lookup_core - sorted address region table
// Lookup: binary search, ending in a hit at probe P or a miss after P probes
//   (P <= 5 with 16 regions), one registered read each.
// Insert: S entries scanned for the sorted position, M moved up one slot.
//   Empty-range and full-table inserts are rejected.
// One beat in flight; next beat taken the cycle after the result is loaded.
// Reset (aresetn low, synchronous) empties the table; no clearing pass.
// ---------------------------------------------------------------------------
module memory_region_table_lookup_core
    import mrt_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // region_start[63:0], region_end[127:64], region_kind[130:128], decl_read[131],
    // decl_write[132], decl_exec[133], seen_read[134], seen_write[135],
    // seen_exec[136], lookup_addr[200:137], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // region_number[4:0], kind_out[7:5], declared_perms[10:8], seen_perms[13:11],
    // may_become_exec[14], may_change_perms[15], may_drift_symbols[16],
    // may_retarget_edges[17], exec_violation[18], write_violation[19], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [2:0]                m_tuser
);

    mrt_cmd_t cmd;
    mrt_sts_t sts;

    mrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrt_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_INSERTED || m_tuser == STAT_EMPTY ||
                      m_tuser == STAT_FULL || m_tuser == STAT_HIT || m_tuser == STAT_MISS))
        else $error("result beat carries an unknown status");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_EMPTY || m_tuser == STAT_FULL ||
                      m_tuser == STAT_MISS)) |-> (m_tdata == '0))
        else $error("reject or miss result carries non-zero fields");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a beat is still being processed");

endmodule
`default_nettype wire
